>>> src/gbs_pkg.sv
package gbs_pkg;

  // Field widths fixed by the interface
  localparam int CP_W         = 21;
  localparam int CLASS_W      = 3;
  localparam int OUT_CNT_W    = 16;
  localparam int COUNT_BITS_DEFAULT = 16;

  // Character classes
  localparam logic [CLASS_W-1:0] CLS_OTHER   = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_CR      = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_LF      = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_CONTROL = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_EXTEND  = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_ZWJ     = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_RI      = 3'd6;
  localparam logic [CLASS_W-1:0] CLS_PICTO   = 3'd7;

  // Join state of the segmenter
  typedef enum logic [2:0] {
    MODE_START     = 3'd0,
    MODE_AFTER_CR  = 3'd1,
    MODE_CLOSED    = 3'd2,
    MODE_ABSORB    = 3'd3,
    MODE_RI_ABSORB = 3'd4
  } mode_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last;
  } in_beat_t;

  typedef struct packed {
    logic                 starts_cluster;
    logic [CLASS_W-1:0]   char_class;
    logic [OUT_CNT_W-1:0] cluster_count;
    logic                 end_of_text;
  } out_beat_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [CLASS_W-1:0] char_class;
    logic               last;
  } cls_item_t;

endpackage

>>> src/grapheme_boundary_segmenter.sv
// Grapheme boundary segmenter: takes one decoded code point per beat, gives
// one result beat per code point with its character class, a flag for a
// cluster boundary before it, and the saturating cluster count of the text
// so far (low 16 bits of a COUNT_BITS counter). A beat with last set closes
// the text and clears the count and join state for the next one. Sustained
// rate is one beat per cycle while the output is not stalled, set by the
// join-state update in the back end; a beat passes through the classifier
// register, the queue and the output register before it is presented. A
// classifier stage and a two-entry queue in front of the state update let
// the input keep flowing while the output is stalled, until the queue fills.
module grapheme_boundary_segmenter #(
  parameter int COUNT_BITS = gbs_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gbs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gbs_pkg::out_beat_t out_data
);
  import gbs_pkg::*;

  logic      push, q_full, q_valid, pop;
  cls_item_t push_item, q_item;

  gbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  gbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  gbs_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> src/gbs_front.sv
module gbs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gbs_pkg::in_beat_t in_data,
  output logic              push,
  output gbs_pkg::cls_item_t push_item,
  input  logic              q_full
);
  import gbs_pkg::*;

  logic               vld_r, vld_nxt;
  cls_item_t          item_r;
  logic [CLASS_W-1:0] cls;
  logic               accept;

  function automatic logic [CLASS_W-1:0] classify(input logic [CP_W-1:0] cp);
    logic [CLASS_W-1:0] c;
    begin
      c = CLS_OTHER;
      if (cp == 21'h00000D) begin
        c = CLS_CR;
      end else if (cp == 21'h00000A) begin
        c = CLS_LF;
      end else if (cp < 21'h000020 || (cp >= 21'h00007F && cp < 21'h0000A0)) begin
        c = CLS_CONTROL;
      end else if ((cp >= 21'h000300 && cp <= 21'h00036F) ||
                   (cp >= 21'h001AB0 && cp <= 21'h001AFF) ||
                   (cp >= 21'h001DC0 && cp <= 21'h001DFF) ||
                   (cp >= 21'h0020D0 && cp <= 21'h0020FF) ||
                   (cp >= 21'h00FE20 && cp <= 21'h00FE2F)) begin
        c = CLS_EXTEND;
      end else if (cp == 21'h00200D) begin
        c = CLS_ZWJ;
      end else if (cp >= 21'h01F1E6 && cp <= 21'h01F1FF) begin
        c = CLS_RI;
      end else if ((cp >= 21'h01F300 && cp <= 21'h01FAFF) ||
                   (cp >= 21'h01F000 && cp <= 21'h01F02F)) begin
        c = CLS_PICTO;
      end
      return c;
    end
  endfunction

  // Classify the incoming code point
  assign cls = classify(in_data.code_point);

  // Hold the stage while the queue is full
  assign push      = vld_r && !q_full;
  assign in_stall  = vld_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push_item = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture the classified beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.char_class <= cls;
      item_r.last       <= in_data.last;
    end
  end

endmodule

>>> src/gbs_queue.sv
module gbs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gbs_pkg::cls_item_t push_item,
  output logic               full,
  output logic               q_valid,
  output gbs_pkg::cls_item_t q_item,
  input  logic               pop
);
  import gbs_pkg::*;

  localparam int DEPTH = 2;

  cls_item_t  entry_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'(DEPTH));
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/gbs_back.sv
module gbs_back #(
  parameter int COUNT_BITS = gbs_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  gbs_pkg::cls_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output gbs_pkg::out_beat_t out_data
);
  import gbs_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic                  out_vld_r, out_vld_nxt;
  out_beat_t             out_r;
  logic                  starts;
  logic [OUT_CNT_W-1:0]  cnt_low;
  logic [CLASS_W-1:0]    c;

  assign c = q_item.char_class;

  // Take a beat whenever the output register is free or draining
  assign pop       = q_valid && (!out_vld_r || !out_stall);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Next join state
  always_comb begin
    unique case (mode_r)
      MODE_AFTER_CR: begin
        if (c == CLS_LF) begin
          mode_nxt = MODE_CLOSED;
        end else begin
          mode_nxt = MODE_CLOSED;
          if (c == CLS_CR) mode_nxt = MODE_AFTER_CR;
          else if (c == CLS_RI) mode_nxt = MODE_RI_ABSORB;
          else if (c != CLS_CONTROL && c != CLS_LF) mode_nxt = MODE_ABSORB;
        end
      end
      MODE_ABSORB, MODE_RI_ABSORB: begin
        if (c == CLS_EXTEND || c == CLS_ZWJ) begin
          mode_nxt = mode_r;
        end else if (mode_r == MODE_RI_ABSORB && c == CLS_RI) begin
          mode_nxt = MODE_CLOSED;
        end else begin
          mode_nxt = MODE_CLOSED;
          if (c == CLS_CR) mode_nxt = MODE_AFTER_CR;
          else if (c == CLS_RI) mode_nxt = MODE_RI_ABSORB;
          else if (c != CLS_CONTROL && c != CLS_LF) mode_nxt = MODE_ABSORB;
        end
      end
      default: begin
        mode_nxt = MODE_CLOSED;
        if (c == CLS_CR) mode_nxt = MODE_AFTER_CR;
        else if (c == CLS_RI) mode_nxt = MODE_RI_ABSORB;
        else if (c != CLS_CONTROL && c != CLS_LF) mode_nxt = MODE_ABSORB;
      end
    endcase
    if (q_item.last) begin
      mode_nxt = MODE_START;
    end
    if (!pop) begin
      mode_nxt = mode_r;
    end
  end

  // Boundary decision
  always_comb begin
    unique case (mode_r)
      MODE_AFTER_CR:  starts = (c != CLS_LF);
      MODE_ABSORB:    starts = !(c == CLS_EXTEND || c == CLS_ZWJ);
      MODE_RI_ABSORB: starts = !(c == CLS_EXTEND || c == CLS_ZWJ || c == CLS_RI);
      default:        starts = 1'b1;
    endcase
  end

  // Saturating cluster count
  always_comb begin
    cnt_upd = cnt_r;
    if (starts && (cnt_r != {COUNT_BITS{1'b1}})) begin
      cnt_upd = cnt_r + COUNT_BITS'(1);
    end
    cnt_nxt = cnt_r;
    if (pop) begin
      cnt_nxt = q_item.last ? '0 : cnt_upd;
    end
  end

  generate
    if (COUNT_BITS >= OUT_CNT_W) begin : g_cnt_trunc
      assign cnt_low = cnt_upd[OUT_CNT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_low = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, cnt_upd};
    end
  endgenerate

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (pop) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_START;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (pop) begin
      out_r.starts_cluster <= starts;
      out_r.char_class     <= c;
      out_r.cluster_count  <= cnt_low;
      out_r.end_of_text    <= q_item.last;
    end
  end

endmodule

>>> bench/tb.sv
module tb;
  import gbs_pkg::*;

  localparam int CNT_BITS   = COUNT_BITS_DEFAULT;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 450;

  // Score predicted segmentation results against accepted output beats
  class cluster_scoreboard;
    mode_t           seg_state;
    longint unsigned clusters_in_text;
    out_beat_t       predicted_beats[$];
    int              failures;

    function new();
      seg_state        = MODE_START;
      clusters_in_text = 0;
      failures         = 0;
    endfunction

    function logic [CLASS_W-1:0] class_of(logic [CP_W-1:0] cp);
      if (cp == 21'h0000D) return CLS_CR;
      if (cp == 21'h0000A) return CLS_LF;
      if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) return CLS_CONTROL;
      if ((cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
          (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h20D0 && cp <= 21'h20FF) ||
          (cp >= 21'hFE20 && cp <= 21'hFE2F))
        return CLS_EXTEND;
      if (cp == 21'h200D) return CLS_ZWJ;
      if (cp >= 21'h1F1E6 && cp <= 21'h1F1FF) return CLS_RI;
      if ((cp >= 21'h1F300 && cp <= 21'h1FAFF) || (cp >= 21'h1F000 && cp <= 21'h1F02F))
        return CLS_PICTO;
      return CLS_OTHER;
    endfunction

    // State a freshly opened cluster moves to, by the class that opens it
    function mode_t mode_for_opener(logic [CLASS_W-1:0] cls);
      if (cls == CLS_CR) return MODE_AFTER_CR;
      if (cls == CLS_LF || cls == CLS_CONTROL) return MODE_CLOSED;
      if (cls == CLS_RI) return MODE_RI_ABSORB;
      return MODE_ABSORB;
    endfunction

    function void note_code_point(in_beat_t b);
      logic [CLASS_W-1:0] cls;
      logic               opens;
      mode_t              nxt;
      out_beat_t          res;
      longint unsigned    count_max;
      cls       = class_of(b.code_point);
      count_max = (64'd1 << CNT_BITS) - 64'd1;
      opens     = 1'b1;
      // Join CR LF, absorb marks, pair regional indicators
      if (seg_state == MODE_AFTER_CR && cls == CLS_LF) begin
        opens = 1'b0;
        nxt   = MODE_CLOSED;
      end else if ((seg_state == MODE_ABSORB || seg_state == MODE_RI_ABSORB) &&
                   (cls == CLS_EXTEND || cls == CLS_ZWJ)) begin
        opens = 1'b0;
        nxt   = seg_state;
      end else if (seg_state == MODE_RI_ABSORB && cls == CLS_RI) begin
        opens = 1'b0;
        nxt   = MODE_CLOSED;
      end else begin
        nxt = mode_for_opener(cls);
      end
      // Count the new cluster, hold at all ones
      if (opens && clusters_in_text < count_max) clusters_in_text++;
      res.starts_cluster = opens;
      res.char_class     = cls;
      res.cluster_count  = clusters_in_text[OUT_CNT_W-1:0];
      res.end_of_text    = b.last;
      predicted_beats.push_back(res);
      // Clear everything at the end of a text
      if (b.last) begin
        seg_state        = MODE_START;
        clusters_in_text = 0;
      end else begin
        seg_state = nxt;
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (predicted_beats.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: start=%0b class=%0d count=%0d eot=%0b",
                   got.starts_cluster, got.char_class, got.cluster_count, got.end_of_text);
        return;
      end
      want = predicted_beats.pop_front();
      if (got.starts_cluster !== want.starts_cluster || got.char_class !== want.char_class ||
          got.cluster_count !== want.cluster_count || got.end_of_text !== want.end_of_text) begin
        failures++;
        // Fields in order: start / class / count / eot
        if (failures <= 10)
          $display("mismatch: expected %0b/%0d/%0d/%0b, got %0b/%0d/%0d/%0b",
                   want.starts_cluster, want.char_class, want.cluster_count, want.end_of_text,
                   got.starts_cluster, got.char_class, got.cluster_count, got.end_of_text);
      end
    endfunction

    function int pending_results();
      return predicted_beats.size();
    endfunction
  endclass

  typedef enum {RX_FLOW, RX_HALF, RX_HEAVY, RX_EVERY3} rx_style_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  cluster_scoreboard sb;
  in_beat_t  text_beats[$];
  int        burst_left   = 0;
  int        random_sent  = 0;
  int        idle_cycles  = 0;
  rx_style_t rx_style     = RX_FLOW;
  int        rx_left      = 0;
  int        rx_phase     = 0;

  logic [CP_W-1:0] directed_cps [0:24] = '{
    21'h000000, 21'h00000D, 21'h00000A, 21'h00000D, 21'h00000D,
    21'h00001F, 21'h000020, 21'h00007F, 21'h00009F, 21'h0000A0,
    21'h000300, 21'h00200D, 21'h00036F, 21'h01F1E6, 21'h00FE2F,
    21'h01F1FF, 21'h01F1E6, 21'h01F300, 21'h0020D0, 21'h01FAFF,
    21'h01F02F, 21'h00D800, 21'h1FFFFF, 21'h001AB0, 21'h001DFF
  };

  // Values just outside the classified ranges, and high values of class other
  logic [CP_W-1:0] other_edges [0:20] = '{
    21'h0002FF, 21'h000370, 21'h001AAF, 21'h001B00, 21'h001DBF, 21'h001E00,
    21'h0020CF, 21'h002100, 21'h00FE1F, 21'h00FE30, 21'h00200C, 21'h00200E,
    21'h01F1E5, 21'h01F200, 21'h01F2FF, 21'h01FB00, 21'h01EFFF, 21'h01F030,
    21'h10FFFF, 21'h110000, 21'h1FFFFF
  };

  grapheme_boundary_segmenter #(.COUNT_BITS(CNT_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Stall the output in styles that change at random
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_left == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_left  <= $urandom_range(8, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_FLOW:  out_stall <= 1'b0;
      RX_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
      default:  out_stall <= (rx_phase % 3 == 0);
    endcase
  end

  // Sample both channels on the falling edge before the edge that accepts a beat
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_code_point(in_data);
      if (out_valid && !out_stall) sb.check_beat(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("grapheme_boundary_segmenter regression: fail");
          $finish;
        end
      end
    end
  end

  function automatic logic [CP_W-1:0] pick_in(logic [CP_W-1:0] lo, logic [CP_W-1:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return CP_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // Pick a code point that is likely of the given class
  function automatic logic [CP_W-1:0] pick_cp(logic [CLASS_W-1:0] cls);
    case (cls)
      CLS_CR:      return 21'h0D;
      CLS_LF:      return 21'h0A;
      CLS_CONTROL: begin
        case ($urandom_range(0, 2))
          0:       return pick_in(21'h00, 21'h1F);
          default: return pick_in(21'h7F, 21'h9F);
        endcase
      end
      CLS_EXTEND: begin
        case ($urandom_range(0, 4))
          0:       return pick_in(21'h0300, 21'h036F);
          1:       return pick_in(21'h1AB0, 21'h1AFF);
          2:       return pick_in(21'h1DC0, 21'h1DFF);
          3:       return pick_in(21'h20D0, 21'h20FF);
          default: return pick_in(21'hFE20, 21'hFE2F);
        endcase
      end
      CLS_ZWJ:     return 21'h200D;
      CLS_RI:      return pick_in(21'h1F1E6, 21'h1F1FF);
      CLS_PICTO: begin
        if ($urandom_range(0, 2) == 0) return pick_in(21'h1F000, 21'h1F02F);
        return pick_in(21'h1F300, 21'h1FAFF);
      end
      default: begin
        case ($urandom_range(0, 6))
          0:       return other_edges[$urandom_range(0, 20)];
          1:       return CP_W'($urandom_range(21'h7E, 21'h20));
          2:       return CP_W'($urandom_range(21'h2FF, 21'hA0));
          3:       return CP_W'($urandom_range(21'hDFFF, 21'hD800));
          4:       return CP_W'($urandom_range(21'h1FFFFF, 21'h110000));
          5:       return CP_W'($urandom_range(21'h10FFFF, 21'h1FB00));
          default: return CP_W'($urandom_range(21'h1AAF, 21'h370));
        endcase
      end
    endcase
  endfunction

  // Drive one beat, idling between bursts, and wait for its acceptance
  task automatic send_beat(input in_beat_t b);
    int  gap;
    bit  took;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      in_data  <= in_beat_t'($urandom_range(32'h3FFFFF, 0));
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    burst_left--;
  endtask

  // Hold the input until every predicted beat has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results() != 0);
    burst_left = 0;
  endtask

  function automatic void add_cp(logic [CP_W-1:0] cp);
    in_beat_t b;
    b.code_point = cp;
    b.last       = 1'b0;
    text_beats.push_back(b);
  endfunction

  function automatic void add_marks();
    repeat ($urandom_range(0, 3))
      add_cp(pick_cp(($urandom_range(0, 2) == 0) ? CLS_ZWJ : CLS_EXTEND));
  endfunction

  // Build a text from well-formed clusters with some stray beats, then send it
  task automatic send_text();
    int n_clusters;
    in_beat_t b;
    text_beats.delete();
    n_clusters = $urandom_range(1, 8);
    repeat (n_clusters) begin
      case ($urandom_range(0, 9))
        0: begin
          add_cp(pick_cp(CLS_CR));
          add_cp(pick_cp(CLS_LF));
        end
        1: add_cp(pick_cp(CLS_CR));
        2: add_cp(pick_cp(CLS_LF));
        3: add_cp(pick_cp(CLS_CONTROL));
        4: begin
          add_cp(pick_cp(CLS_OTHER));
          add_marks();
        end
        5: begin
          add_cp(pick_cp(CLS_PICTO));
          add_marks();
          if ($urandom_range(0, 1) == 0) begin
            add_cp(pick_cp(CLS_ZWJ));
            add_cp(pick_cp(CLS_PICTO));
          end
        end
        6: begin
          add_cp(pick_cp(CLS_RI));
          add_marks();
          add_cp(pick_cp(CLS_RI));
          add_marks();
        end
        7: begin
          add_cp(pick_cp(CLS_RI));
          add_marks();
        end
        8: add_marks();
        default: add_cp(CP_W'($urandom_range(21'h1FFFFF, 0)));
      endcase
    end
    if (text_beats.size() == 0) add_cp(pick_cp(CLS_EXTEND));
    // Most texts close on their final beat; a few run on into the next
    if ($urandom_range(0, 9) != 0) text_beats[text_beats.size() - 1].last = 1'b1;
    foreach (text_beats[k]) begin
      b = text_beats[k];
      if ($urandom_range(0, 19) == 0) b.last = 1'b1;
      send_beat(b);
    end
    random_sent += text_beats.size();
  endtask

  initial begin
    in_beat_t b;
    bit       drained_mid;
    drained_mid = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: range edges, CR LF joining, marks, indicator pairs, text ends
    for (int i = 0; i < 25; i++) begin
      b.code_point = directed_cps[i];
      b.last       = (i == 22 || i == 24);
      send_beat(b);
    end
    hold_until_drained();

    // Random texts, with one full drain part way through
    while (random_sent < RANDOM_ITEMS) begin
      send_text();
      if (!drained_mid && random_sent >= RANDOM_ITEMS / 2) begin
        hold_until_drained();
        drained_mid = 1'b1;
      end
    end
    hold_until_drained();

    // Close a text, then open the next one with a lone mark
    b.code_point = pick_cp(CLS_OTHER);
    b.last       = 1'b1;
    send_beat(b);
    b.code_point = pick_cp(CLS_EXTEND);
    send_beat(b);
    hold_until_drained();

    // Allow for stray beats after the last expected one
    repeat (12) @(posedge clk);
    if (sb.failures == 0 && sb.pending_results() == 0) begin
      $display("grapheme_boundary_segmenter regression: pass");
    end else begin
      $display("grapheme_boundary_segmenter regression: fail");
    end
    $finish;
  end

endmodule
